>>> src/i2cbr_pkg.sv
// ----------------------------------------------------------------------------
// i2cbr_pkg
// Shared types, register indexes, status codes and reset values for the
// I2C bus recovery sequencer.
// ----------------------------------------------------------------------------
package i2cbr_pkg;

  localparam int unsigned TimerBitsDef = 20;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SETTLE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_POLL       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PULSES = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_POLLS  = 3'd4;

  // Completion status codes
  localparam logic [1:0] ST_CLEARED  = 2'd0;
  localparam logic [1:0] ST_SCL_LOW  = 2'd1;
  localparam logic [1:0] ST_STRETCH  = 2'd2;
  localparam logic [1:0] ST_SDA_STUCK = 2'd3;

  // Register reset values
  localparam logic [19:0] SettleRst     = 20'd500000;
  localparam logic [9:0]  HalfRst       = 10'd10;
  localparam logic [19:0] PollRst       = 20'd100000;
  localparam logic [7:0]  MaxPulsesRst  = 8'd20;
  localparam logic [7:0]  MaxPollsRst   = 8'd20;

  typedef struct packed {
    logic [19:0] settle_ticks;
    logic [9:0]  half_period_ticks;
    logic [19:0] poll_interval_ticks;
    logic [7:0]  max_clock_pulses;
    logic [7:0]  max_stretch_polls;
  } cfg_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       pullups_on;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

>>> src/i2cbr_ifs.sv
// ----------------------------------------------------------------------------
// i2cbr channel interfaces
// Valid/ready channels for tick requests, results and register writes.
// ----------------------------------------------------------------------------

interface i2cbr_req_if;
  logic valid;
  logic ready;
  logic func;
  logic scl_level;
  logic sda_level;

  modport source (output valid, func, scl_level, sda_level, input ready);
  modport sink   (input valid, func, scl_level, sda_level, output ready);
endinterface

interface i2cbr_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       pullups_on;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_drive_low, sda_drive_low, pullups_on, busy_res,
                  done_res, status, input ready);
  modport sink   (input valid, scl_drive_low, sda_drive_low, pullups_on, busy_res,
                  done_res, status, output ready);
endinterface

interface i2cbr_cfg_if import i2cbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/i2cbr_seq.sv
// ----------------------------------------------------------------------------
// i2cbr_seq
// Recovery state machine: holds phase, wait timer and counters, advances
// once per accepted request and produces the next result view.
// ----------------------------------------------------------------------------
module i2cbr_seq import i2cbr_pkg::*; #(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic func_i,
  input  logic scl_i,
  input  logic sda_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_PULSE_LOW,
    PH_PULSE_HIGH,
    PH_STRETCH,
    PH_START_LOW,
    PH_STOP_HIGH
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [7:0]            pulses_q, pulses_d;
  logic [7:0]            polls_q, polls_d;
  logic [1:0]            status_q, status_d;
  logic                  pullup_q, pullup_d;

  logic                  decide;
  logic                  fin;
  logic [1:0]            fin_code;
  logic [7:0]            polls_dec;

  assign polls_dec = polls_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    pulses_d = pulses_q;
    polls_d  = polls_q;
    status_d = status_q;
    pullup_d = pullup_q;
    decide   = 1'b0;
    fin      = 1'b0;
    fin_code = ST_CLEARED;

    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        if (func_i) begin
          pullup_d = 1'b1;
          pulses_d = cfg_i.max_clock_pulses;
          polls_d  = '0;
          timer_d  = TIMER_BITS'(cfg_i.settle_ticks);
          phase_d  = PH_SETTLE;
        end
      end else if (!func_i) begin
        if (timer_q > TIMER_BITS'(1)) begin
          timer_d = timer_q - TIMER_BITS'(1);
        end else begin
          timer_d = '0;
          unique case (phase_q)
            PH_SETTLE: begin
              if (!scl_i) begin
                fin      = 1'b1;
                fin_code = ST_SCL_LOW;
              end else begin
                decide = 1'b1;
              end
            end
            PH_PULSE_LOW: begin
              phase_d = PH_PULSE_HIGH;
              timer_d = TIMER_BITS'(cfg_i.half_period_ticks);
            end
            PH_PULSE_HIGH: begin
              if (!scl_i) begin
                polls_d = cfg_i.max_stretch_polls;
                if (cfg_i.max_stretch_polls != 8'd0) begin
                  phase_d = PH_STRETCH;
                  timer_d = TIMER_BITS'(cfg_i.poll_interval_ticks);
                end else begin
                  fin      = 1'b1;
                  fin_code = ST_STRETCH;
                end
              end else begin
                decide = 1'b1;
              end
            end
            PH_STRETCH: begin
              polls_d = polls_dec;
              if (scl_i) begin
                decide = 1'b1;
              end else if (polls_dec != 8'd0) begin
                timer_d = TIMER_BITS'(cfg_i.poll_interval_ticks);
              end else begin
                fin      = 1'b1;
                fin_code = ST_STRETCH;
              end
            end
            PH_START_LOW: begin
              phase_d = PH_STOP_HIGH;
              timer_d = TIMER_BITS'(cfg_i.half_period_ticks);
            end
            PH_STOP_HIGH: begin
              pullup_d = 1'b0;
              fin      = 1'b1;
              fin_code = ST_CLEARED;
            end
            default: begin
            end
          endcase

          // SCL is known high here: clock again while SDA stays low
          if (decide) begin
            if (!sda_i) begin
              if (pulses_q != 8'd0) begin
                pulses_d = pulses_q - 8'd1;
                phase_d  = PH_PULSE_LOW;
                timer_d  = TIMER_BITS'(cfg_i.half_period_ticks);
              end else begin
                fin      = 1'b1;
                fin_code = ST_SDA_STUCK;
              end
            end else begin
              phase_d = PH_START_LOW;
              timer_d = TIMER_BITS'(cfg_i.half_period_ticks);
            end
          end

          if (fin) begin
            status_d = fin_code;
            phase_d  = PH_IDLE;
            timer_d  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      timer_q  <= '0;
      pulses_q <= '0;
      polls_q  <= '0;
      status_q <= ST_CLEARED;
      pullup_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      pulses_q <= pulses_d;
      polls_q  <= polls_d;
      status_q <= status_d;
      pullup_q <= pullup_d;
    end
  end

  always_comb begin
    res_o.scl_drive_low = (phase_d == PH_PULSE_LOW);
    res_o.sda_drive_low = (phase_d == PH_START_LOW);
    res_o.pullups_on    = pullup_d;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.done_res      = fin;
    res_o.status        = status_d;
  end

  // Pull-ups stay on for the whole sequence
  a_pullup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> pullup_q)
    else $error("pull-ups off during recovery");

  // Stretch polling always has at least one poll left
  a_stretch_polls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STRETCH |-> polls_q != 8'd0)
    else $error("stretch phase with no polls left");

  // Without a request the sequencer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(timer_q) && $stable(pulses_q))
    else $error("state moved without a request");

  // A start from idle always enters the settle wait
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && func_i && phase_q == PH_IDLE |=> phase_q == PH_SETTLE && pullup_q)
    else $error("start did not enter settle");

endmodule

>>> src/i2c_bus_recovery_core.sv
// ----------------------------------------------------------------------------
// i2c_bus_recovery_core
// Latency: a result is valid in the cycle after its tick request is accepted.
// Throughput: one request per cycle while the consumer keeps taking results; the
//   state update is a single registered step and the result register frees as soon as the consumer takes it.
// Reset: rst_ni clears the sequencer to idle with pull-ups off and status 0,
//   and loads the register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module i2c_bus_recovery_core import i2cbr_pkg::*; #(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbr_cfg_if.sink   cfg_i,
  i2cbr_req_if.sink   req_i,
  i2cbr_res_if.source res_o
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic req_fire;
  logic cfg_fire;

  // Registers are always writable
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Take a new request whenever the result slot is empty or draining
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks        <= SettleRst;
      cfg_q.half_period_ticks   <= HalfRst;
      cfg_q.poll_interval_ticks <= PollRst;
      cfg_q.max_clock_pulses    <= MaxPulsesRst;
      cfg_q.max_stretch_polls   <= MaxPollsRst;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        CFG_SETTLE:     cfg_q.settle_ticks        <= cfg_i.data;
        CFG_HALF:       cfg_q.half_period_ticks   <= cfg_i.data[9:0];
        CFG_POLL:       cfg_q.poll_interval_ticks <= cfg_i.data;
        CFG_MAX_PULSES: cfg_q.max_clock_pulses    <= cfg_i.data[7:0];
        CFG_MAX_POLLS:  cfg_q.max_stretch_polls   <= cfg_i.data[7:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Sequencer advances exactly once per accepted request
  i2cbr_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (req_fire),
    .func_i (req_i.func),
    .scl_i  (req_i.scl_level),
    .sda_i  (req_i.sda_level),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.scl_drive_low = res_q.scl_drive_low;
  assign res_o.sda_drive_low = res_q.sda_drive_low;
  assign res_o.pullups_on    = res_q.pullups_on;
  assign res_o.busy_res      = res_q.busy_res;
  assign res_o.done_res      = res_q.done_res;
  assign res_o.status        = res_q.status;

  // Every accepted request yields a result next cycle
  a_req_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // A clean finish always drops the pull-ups
  a_clean_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res && res_q.status == ST_CLEARED |-> !res_q.pullups_on)
    else $error("pull-ups left on after bus cleared");

  // A settle write lands in the register
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire && cfg_i.index == CFG_SETTLE |=> cfg_q.settle_ticks == $past(cfg_i.data))
    else $error("settle register write lost");

endmodule

>>> sim/i2cbr_tb_pkg.sv
// ----------------------------------------------------------------------------
// i2cbr_tb_pkg
// Request function codes shared by the recovery sequencer bench and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbr_tb_pkg;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

endpackage

>>> sim/i2cbr_checker.sv
// ----------------------------------------------------------------------------
// i2cbr_checker
// Watches the register, request and result channels of the bus recovery
// sequencer, predicts one result per accepted request and compares each
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbr_checker import i2cbr_pkg::*, i2cbr_tb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cbr_cfg_if  cfg_mon,
  i2cbr_req_if  req_mon,
  i2cbr_res_if  res_mon,
  output int    mismatches_o,
  output int    pending_o
);

  // Keep the log short when a broken design fails on every result.
  localparam int PrintCap = 40;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_SETTLE,
    SEQ_PULSE_LOW,
    SEQ_PULSE_HIGH,
    SEQ_STRETCH,
    SEQ_START_LOW,
    SEQ_STOP_HIGH
  } seq_phase_e;

  cfg_t                    model_cfg;
  seq_phase_e              seq_phase;
  logic [TimerBitsDef-1:0] wait_cnt;
  logic [7:0]              pulses_left;
  logic [7:0]              polls_left;
  logic [1:0]              last_status;
  logic                    pullups;
  logic                    done_now;
  res_t                    expected_q[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches_o < PrintCap) begin
      $display("%0t ns: result mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  task automatic end_sequence(input logic [1:0] code);
    last_status = code;
    seq_phase   = SEQ_IDLE;
    wait_cnt    = '0;
    done_now    = 1'b1;
  endtask

  // SCL is known high here: pulse again, give up, or go on to START/STOP.
  task automatic decide_on_sda(input logic sda);
    if (!sda) begin
      if (pulses_left != 8'd0) begin
        pulses_left = pulses_left - 8'd1;
        seq_phase   = SEQ_PULSE_LOW;
        wait_cnt    = TimerBitsDef'(model_cfg.half_period_ticks);
      end else begin
        end_sequence(ST_SDA_STUCK);
      end
    end else begin
      seq_phase = SEQ_START_LOW;
      wait_cnt  = TimerBitsDef'(model_cfg.half_period_ticks);
    end
  endtask

  task automatic advance_sequencer(input logic fn, input logic scl, input logic sda,
                                   output res_t r);
    done_now = 1'b0;
    if (seq_phase == SEQ_IDLE) begin
      if (fn == FUNC_START) begin
        pullups     = 1'b1;
        pulses_left = model_cfg.max_clock_pulses;
        polls_left  = 8'd0;
        wait_cnt    = TimerBitsDef'(model_cfg.settle_ticks);
        seq_phase   = SEQ_SETTLE;
      end
    end else if (fn == FUNC_TICK) begin
      if (wait_cnt > 1) begin
        wait_cnt = wait_cnt - 1'b1;
      end else begin
        wait_cnt = '0;
        case (seq_phase)
          SEQ_SETTLE: begin
            if (!scl) end_sequence(ST_SCL_LOW);
            else decide_on_sda(sda);
          end
          SEQ_PULSE_LOW: begin
            seq_phase = SEQ_PULSE_HIGH;
            wait_cnt  = TimerBitsDef'(model_cfg.half_period_ticks);
          end
          SEQ_PULSE_HIGH: begin
            if (!scl) begin
              polls_left = model_cfg.max_stretch_polls;
              if (polls_left != 8'd0) begin
                seq_phase = SEQ_STRETCH;
                wait_cnt  = TimerBitsDef'(model_cfg.poll_interval_ticks);
              end else begin
                end_sequence(ST_STRETCH);
              end
            end else begin
              decide_on_sda(sda);
            end
          end
          SEQ_STRETCH: begin
            polls_left = polls_left - 8'd1;
            if (scl) decide_on_sda(sda);
            else if (polls_left != 8'd0) wait_cnt = TimerBitsDef'(model_cfg.poll_interval_ticks);
            else end_sequence(ST_STRETCH);
          end
          SEQ_START_LOW: begin
            seq_phase = SEQ_STOP_HIGH;
            wait_cnt  = TimerBitsDef'(model_cfg.half_period_ticks);
          end
          SEQ_STOP_HIGH: begin
            pullups = 1'b0;
            end_sequence(ST_CLEARED);
          end
          default: ;
        endcase
      end
    end
    r.scl_drive_low = (seq_phase == SEQ_PULSE_LOW);
    r.sda_drive_low = (seq_phase == SEQ_START_LOW);
    r.pullups_on    = pullups;
    r.busy_res      = (seq_phase != SEQ_IDLE);
    r.done_res      = done_now;
    r.status        = last_status;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t fresh;
    if (!rst_ni) begin
      model_cfg = '{settle_ticks: SettleRst, half_period_ticks: HalfRst,
                    poll_interval_ticks: PollRst, max_clock_pulses: MaxPulsesRst,
                    max_stretch_polls: MaxPollsRst};
      seq_phase   = SEQ_IDLE;
      wait_cnt    = '0;
      pulses_left = 8'd0;
      polls_left  = 8'd0;
      last_status = ST_CLEARED;
      pullups     = 1'b0;
      done_now    = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SETTLE:     model_cfg.settle_ticks        = cfg_mon.data[19:0];
          CFG_HALF:       model_cfg.half_period_ticks   = cfg_mon.data[9:0];
          CFG_POLL:       model_cfg.poll_interval_ticks = cfg_mon.data[19:0];
          CFG_MAX_PULSES: model_cfg.max_clock_pulses    = cfg_mon.data[7:0];
          CFG_MAX_POLLS:  model_cfg.max_stretch_polls   = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      // Compare before predicting: a result always belongs to an earlier request.
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (res_mon.scl_drive_low !== want.scl_drive_low)
            report_mismatch("scl_drive_low", res_mon.scl_drive_low, want.scl_drive_low);
          if (res_mon.sda_drive_low !== want.sda_drive_low)
            report_mismatch("sda_drive_low", res_mon.sda_drive_low, want.sda_drive_low);
          if (res_mon.pullups_on !== want.pullups_on)
            report_mismatch("pullups_on", res_mon.pullups_on, want.pullups_on);
          if (res_mon.busy_res !== want.busy_res)
            report_mismatch("busy_res", res_mon.busy_res, want.busy_res);
          if (res_mon.done_res !== want.done_res)
            report_mismatch("done_res", res_mon.done_res, want.done_res);
          if (res_mon.status !== want.status)
            report_mismatch("status", res_mon.status, want.status);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        advance_sequencer(req_mon.func, req_mon.scl_level, req_mon.sda_level, fresh);
        expected_q.push_back(fresh);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

>>> sim/i2c_bus_recovery_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_bus_recovery_core_tb
// Drives tick and start requests with sampled line levels into the bus
// recovery sequencer under several register settings, stalls the result
// side on its own pattern, and leaves prediction and checking to the
// i2cbr_checker instance; gives the verdict once all results are home.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_bus_recovery_core_tb;
  import i2cbr_pkg::*;
  import i2cbr_tb_pkg::*;

  // Receiver hold-off long enough to back up the result register and the input.
  localparam int unsigned LongHold      = 300;
  // Cycles with no request, result or register write moving before we give up.
  localparam int unsigned WatchdogLimit = 4000;
  // Bound on ticks sent while waiting for one sequence to end.
  localparam int unsigned SeqTickCap    = 20000;
  localparam int unsigned EndWait       = 10;

  // How the sampled SCL/SDA levels behave during one recovery sequence.
  typedef enum int unsigned {
    LINES_CLEAN,
    LINES_SCL_LOW,
    LINES_SDA_STUCK,
    LINES_RELEASE,
    LINES_STRETCH,
    LINES_NOISE
  } line_mode_e;

  typedef struct packed {
    logic fn;
    logic scl;
    logic sda;
  } tick_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          mismatches;
  int          pending;

  int unsigned req_seen      = 0;
  int unsigned res_seen      = 0;
  int unsigned done_seen     = 0;
  int unsigned settings_used = 0;
  int unsigned squeezes      = 0;
  int unsigned endings [4]   = '{0, 0, 0, 0};
  int unsigned idle_cycles   = 0;
  logic        last_busy     = 1'b0;
  bit          hold_ask      = 1'b0;
  bit          gaps_on       = 1'b1;
  int unsigned burst_left    = 0;

  i2cbr_req_if req_if ();
  i2cbr_res_if res_if ();
  i2cbr_cfg_if cfg_if ();

  i2c_bus_recovery_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  i2cbr_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_if),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Directed requests, run with settle 2 and every other register at 1.
  tick_t directed_ticks [23] = '{
    '{FUNC_TICK,  1'b0, 1'b0},  // idle tick, levels ignored
    '{FUNC_TICK,  1'b1, 1'b1},
    '{FUNC_START, 1'b1, 1'b1},  // start: pull-ups on, settle
    '{FUNC_START, 1'b0, 1'b0},  // start while busy is dropped
    '{FUNC_TICK,  1'b1, 1'b1},
    '{FUNC_TICK,  1'b1, 1'b0},  // SDA low after settle: one pulse
    '{FUNC_TICK,  1'b0, 1'b0},
    '{FUNC_TICK,  1'b0, 1'b0},  // SCL held after the pulse: poll
    '{FUNC_TICK,  1'b0, 1'b1},  // still held, last poll: stretch timeout
    '{FUNC_START, 1'b0, 1'b0},
    '{FUNC_TICK,  1'b0, 1'b0},
    '{FUNC_TICK,  1'b0, 1'b1},  // SCL low after settle
    '{FUNC_START, 1'b1, 1'b1},
    '{FUNC_TICK,  1'b1, 1'b1},
    '{FUNC_TICK,  1'b1, 1'b0},
    '{FUNC_TICK,  1'b1, 1'b1},
    '{FUNC_TICK,  1'b1, 1'b0},  // no pulses left with SDA low: stuck
    '{FUNC_START, 1'b1, 1'b1},
    '{FUNC_TICK,  1'b0, 1'b0},
    '{FUNC_TICK,  1'b1, 1'b1},  // bus free: START
    '{FUNC_TICK,  1'b0, 1'b0},  // STOP
    '{FUNC_TICK,  1'b0, 1'b0},  // cleared, pull-ups drop
    '{FUNC_TICK,  1'b1, 1'b1}
  };

  // Count traffic, note sequence endings and run the watchdog.
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) req_seen++;
    if (res_if.valid && res_if.ready) begin
      res_seen++;
      last_busy = res_if.busy_res;
      if (res_if.done_res) begin
        done_seen++;
        endings[res_if.status]++;
      end
    end
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               WatchdogLimit, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall in spans of random style; honor one long hold when asked.
  initial begin : receiver
    int unsigned span;
    int unsigned style;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      span  = $urandom_range(16, 200);
      style = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_ask) begin
          // Hold ready low while the sender keeps offering requests.
          hold_ask     = 1'b0;
          res_if.ready = 1'b0;
          repeat (LongHold) @(negedge clk_i);
        end
        case (style)
          0:       res_if.ready = 1'b1;
          1:       res_if.ready = 1'($urandom_range(0, 1));
          default: res_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted; enter and leave on a falling edge.
  task automatic send_req(input logic fn, input logic scl, input logic sda);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_if.valid     = 1'b1;
    req_if.func      = fn;
    req_if.scl_level = scl;
    req_if.sda_level = sda;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_results();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Feed a free bus until the sequencer reports idle, so registers change only at rest.
  task automatic drain_sequencer();
    int unsigned n;
    wait_results();
    n = 0;
    while (last_busy && n < SeqTickCap) begin
      send_req(FUNC_TICK, 1'b1, 1'b1);
      n++;
    end
    wait_results();
  endtask

  // Write all five registers; junk above a narrow register's width must be dropped.
  task automatic write_config(input logic [19:0] settle, input logic [9:0] half,
                              input logic [19:0] poll, input logic [7:0] pulses,
                              input logic [7:0] polls);
    logic [CfgDataW-1:0] value  [5];
    logic [CfgIdxW-1:0]  reg_idx [5];
    int                  k;
    value[0]   = settle;
    value[1]   = {10'($urandom), half};
    value[2]   = poll;
    value[3]   = {12'($urandom), pulses};
    value[4]   = {12'($urandom), polls};
    reg_idx[0] = CFG_SETTLE;
    reg_idx[1] = CFG_HALF;
    reg_idx[2] = CFG_POLL;
    reg_idx[3] = CFG_MAX_PULSES;
    reg_idx[4] = CFG_MAX_POLLS;
    for (k = 0; k < 5; k++) begin
      cfg_if.valid = 1'b1;
      cfg_if.index = reg_idx[k];
      cfg_if.data  = value[k];
      do @(posedge clk_i); while (!cfg_if.ready);
      @(negedge clk_i);
    end
    cfg_if.valid = 1'b0;
    settings_used++;
  endtask

  // One register setting: run recovery sequences until the request budget is spent.
  task automatic run_phase(input logic [19:0] settle, input logic [9:0] half,
                           input logic [19:0] poll, input logic [7:0] pulses,
                           input logic [7:0] polls, input int unsigned budget,
                           input bit squeeze);
    int unsigned first_req;
    int unsigned start_done;
    int unsigned ticks;
    int unsigned release_at;
    int unsigned low_from;
    int unsigned low_to;
    line_mode_e  mode;
    logic        fn;
    logic        scl;
    logic        sda;
    write_config(settle, half, poll, pulses, polls);
    gaps_on   = ($urandom_range(0, 3) != 0);
    first_req = req_seen;
    do begin
      mode       = line_mode_e'($urandom_range(0, 5));
      release_at = $urandom_range(0, 8 * (int'(half) + 1) + int'(settle));
      low_from   = $urandom_range(0, 4 * (int'(half) + 1) + int'(settle));
      low_to     = low_from + $urandom_range(1, (int'(polls) + 1) * (int'(poll) + 1) + 2);
      if (squeeze) begin
        hold_ask = 1'b1;
        squeezes++;
        squeeze  = 1'b0;
      end
      start_done = done_seen;
      send_req(FUNC_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      ticks = 0;
      // Advance until the sequence reports done; a few idle ticks may trail it.
      while (done_seen == start_done && ticks < SeqTickCap) begin
        case (mode)
          LINES_CLEAN: begin
            scl = 1'b1;
            sda = 1'b1;
          end
          LINES_SCL_LOW: begin
            scl = 1'b0;
            sda = 1'($urandom_range(0, 1));
          end
          LINES_SDA_STUCK: begin
            scl = 1'b1;
            sda = 1'b0;
          end
          LINES_RELEASE: begin
            scl = 1'b1;
            sda = (ticks >= release_at);
          end
          LINES_STRETCH: begin
            scl = !(ticks >= low_from && ticks < low_to);
            sda = (ticks >= release_at);
          end
          default: begin
            scl = 1'($urandom_range(0, 1));
            sda = 1'($urandom_range(0, 1));
          end
        endcase
        // Sprinkle starts: dropped while busy, a fresh sequence if it lands idle.
        fn = ($urandom_range(0, 15) == 0) ? FUNC_START : FUNC_TICK;
        send_req(fn, scl, sda);
        ticks++;
      end
      // Now and then pause the sender until every result is home.
      if ($urandom_range(0, 3) == 0) wait_results();
    end while (req_seen - first_req < budget);
    drain_sequencer();
  endtask

  initial begin : stimulus
    logic [19:0] r_settle;
    logic [9:0]  r_half;
    logic [19:0] r_poll;
    logic [7:0]  r_pulses;
    logic [7:0]  r_polls;
    int          k;
    // Known values on every input from time zero.
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_TICK;
    req_if.scl_level = 1'b1;
    req_if.sda_level = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_SETTLE;
    cfg_if.data      = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: every ending, start while busy, idle levels.
    write_config(20'd2, 10'd1, 20'd1, 8'd1, 8'd1);
    for (k = 0; k < 23; k++) begin
      send_req(directed_ticks[k].fn, directed_ticks[k].scl, directed_ticks[k].sda);
    end
    drain_sequencer();

    // Fixed corners: zero settle, all-zero registers, widest counts, long half period.
    run_phase(20'd0, 10'd1, 20'd1, 8'd1, 8'd1, 60, 1'b0);
    run_phase(20'd0, 10'd0, 20'd0, 8'd0, 8'd0, 40, 1'b0);
    run_phase(20'd3, 10'd1, 20'd2, 8'd255, 8'd255, 200, 1'b1);
    run_phase(20'd4, 10'd150, 20'd2, 8'd1, 8'd1, 1, 1'b0);

    // Random small settings; squeeze the result side in some of them.
    repeat (6) begin
      r_settle = 20'($urandom_range(0, 12));
      r_half   = ($urandom_range(0, 5) == 0) ? 10'd0 : 10'($urandom_range(1, 4));
      r_poll   = 20'($urandom_range(1, 6));
      r_pulses = 8'($urandom_range(0, 12));
      r_polls  = 8'($urandom_range(0, 6));
      run_phase(r_settle, r_half, r_poll, r_pulses, r_polls, 50,
                ($urandom_range(0, 2) == 0));
    end

    // Widest timers: load them but only send idle ticks, since one sequence
    // would take at least a million ticks.
    write_config(20'hFFFFF, 10'h3FF, 20'hFFFFF, 8'hFF, 8'hFF);
    for (k = 0; k < 8; k++) begin
      send_req(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    wait_results();
    repeat (EndWait) @(negedge clk_i);

    $display("covered %0d requests and %0d results over %0d register settings, %0d long stalls",
             req_seen, res_seen, settings_used, squeezes);
    $display("sequence endings: cleared %0d, scl low %0d, stretch timeout %0d, sda stuck %0d",
             endings[ST_CLEARED], endings[ST_SCL_LOW], endings[ST_STRETCH],
             endings[ST_SDA_STUCK]);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
